/* rtl/tpsg_pkg.sv */
// Package for the three-phase sample generator: widths, register codes,
// reset values and the quarter-wave cosine table built at elaboration.
// No dependencies.
package tpsg_pkg;

  localparam int unsigned SAMPLES_PER_WRAP = 4000;
  localparam int unsigned COS_TABLE_BITS   = 10;
  localparam int unsigned AMP_BITS         = 24;

  localparam int unsigned IDX_W     = 12;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned LAG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SAMPLE_W  = AMP_BITS + 1;
  localparam int unsigned NEUTRAL_W = AMP_BITS + 3;

  localparam int unsigned COS_FRAC  = 30;
  localparam int unsigned QTR_BITS  = COS_TABLE_BITS - 2;
  localparam int unsigned COS_QUARTER = 2 ** QTR_BITS;

  localparam logic [IDX_W-1:0]   LAST_INDEX = IDX_W'(SAMPLES_PER_WRAP - 1);
  localparam logic [PHASE_W-1:0] THIRD_TURN = 32'd1431655765;
  localparam logic [63:0]        TWO_PI_Q30 = 64'd6746518852;

  localparam logic [COS_TABLE_BITS-1:0] TBL_HALF    = COS_TABLE_BITS'(2 ** (COS_TABLE_BITS - 1));
  localparam logic [COS_TABLE_BITS-1:0] TBL_QUARTER = COS_TABLE_BITS'(COS_QUARTER);

  localparam logic [PHASE_W-1:0]  RST_PHASE_STEP = 32'd53687091;
  localparam logic [LAG_W-1:0]    RST_CUR_LAG    = '0;
  localparam logic [AMP_BITS-1:0] RST_AMP_VOLT   = AMP_BITS'(1555635);
  localparam logic [AMP_BITS-1:0] RST_AMP_CUR    = AMP_BITS'(14142);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 3'd0,
    CFG_CUR_LAG    = 3'd1,
    CFG_AMP_VOLT_A = 3'd2,
    CFG_AMP_VOLT_B = 3'd3,
    CFG_AMP_VOLT_C = 3'd4,
    CFG_AMP_CUR_A  = 3'd5,
    CFG_AMP_CUR_B  = 3'd6,
    CFG_AMP_CUR_C  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                neg;
    logic [AMP_BITS-1:0] mag;
  } chan_res_t;

  typedef logic [COS_FRAC:0] cos_rom_t [COS_QUARTER];

  // cos(m / 2^COS_TABLE_BITS turns) in Q30, truncated Taylor series, clamped
  function automatic logic [COS_FRAC:0] fq_cos(input int unsigned m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (64'(m) * TWO_PI_Q30) >> COS_TABLE_BITS;
    x2   = (x * x) >> COS_FRAC;
    term = 64'(1) << COS_FRAC;
    sum  = longint'(term);
    // terms x^2/2! through x^16/16!
    term = ((term * x2) >> COS_FRAC) / 64'd2;
    sum  = sum - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 64'd12;
    sum  = sum + longint'(term);
    term = ((term * x2) >> COS_FRAC) / 64'd30;
    sum  = sum - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 64'd56;
    sum  = sum + longint'(term);
    term = ((term * x2) >> COS_FRAC) / 64'd90;
    sum  = sum - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 64'd132;
    sum  = sum + longint'(term);
    term = ((term * x2) >> COS_FRAC) / 64'd182;
    sum  = sum - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 64'd240;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << COS_FRAC)) begin
      sum = longint'(1) << COS_FRAC;
    end
    return (COS_FRAC + 1)'(sum);
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int unsigned i = 0; i < COS_QUARTER; i++) begin
      rom[i] = fq_cos(i);
    end
    return rom;
  endfunction

  localparam cos_rom_t             COS_ROM        = build_cos_rom();
  localparam logic [COS_FRAC:0]    COS_AT_QUARTER = fq_cos(COS_QUARTER);

endpackage

/* rtl/tpsg_if.sv */
// Request and result channel interfaces of the sample generator.
// Depends on tpsg_pkg.
interface tpsg_req_if;
  logic valid;
  logic ready;
  logic sample_tick;

  modport source (output valid, output sample_tick, input ready);
  modport sink (input valid, input sample_tick, output ready);
endinterface

interface tpsg_res_if;
  logic                                     valid;
  logic                                     ready;
  logic        [tpsg_pkg::IDX_W-1:0]        sample_index;
  logic signed [tpsg_pkg::SAMPLE_W-1:0]     volt_a;
  logic signed [tpsg_pkg::SAMPLE_W-1:0]     volt_b;
  logic signed [tpsg_pkg::SAMPLE_W-1:0]     volt_c;
  logic signed [tpsg_pkg::NEUTRAL_W-1:0]    volt_neutral;
  logic signed [tpsg_pkg::SAMPLE_W-1:0]     cur_a;
  logic signed [tpsg_pkg::SAMPLE_W-1:0]     cur_b;
  logic signed [tpsg_pkg::SAMPLE_W-1:0]     cur_c;
  logic signed [tpsg_pkg::NEUTRAL_W-1:0]    cur_neutral;

  modport source (
    output valid, output sample_index, output volt_a, output volt_b, output volt_c,
    output volt_neutral, output cur_a, output cur_b, output cur_c, output cur_neutral,
    input ready
  );
  modport sink (
    input valid, input sample_index, input volt_a, input volt_b, input volt_c,
    input volt_neutral, input cur_a, input cur_b, input cur_c, input cur_neutral,
    output ready
  );
endinterface

/* rtl/tpsg_chan.sv */
// One output channel: quarter-wave cosine lookup and amplitude multiply,
// registered as sign and magnitude. Depends on tpsg_pkg.
module tpsg_chan (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [tpsg_pkg::COS_TABLE_BITS-1:0]   tbl_idx_i,
  input  logic [tpsg_pkg::AMP_BITS-1:0]         amp_i,
  output tpsg_pkg::chan_res_t                   res_o
);

  localparam int unsigned ProdW = tpsg_pkg::AMP_BITS + tpsg_pkg::COS_FRAC + 1;

  logic [tpsg_pkg::COS_TABLE_BITS-1:0] k_fold;
  logic [tpsg_pkg::COS_TABLE_BITS-1:0] m;
  logic                                neg;
  logic [tpsg_pkg::COS_FRAC:0]         cos_mag;
  logic [ProdW-1:0]                    prod;
  tpsg_pkg::chan_res_t                 res_d;
  tpsg_pkg::chan_res_t                 res_q;

  always_comb begin
    k_fold = (tbl_idx_i > tpsg_pkg::TBL_HALF) ? -tbl_idx_i : tbl_idx_i;
    neg    = k_fold > tpsg_pkg::TBL_QUARTER;
    m      = neg ? (tpsg_pkg::TBL_HALF - k_fold) : k_fold;
    if (m == tpsg_pkg::TBL_QUARTER) begin
      cos_mag = tpsg_pkg::COS_AT_QUARTER;
    end else begin
      cos_mag = tpsg_pkg::COS_ROM[m[tpsg_pkg::QTR_BITS-1:0]];
    end
    prod      = ProdW'(amp_i) * ProdW'(cos_mag);
    res_d.neg = neg;
    res_d.mag = prod[tpsg_pkg::COS_FRAC +: tpsg_pkg::AMP_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/three_phase_sample_generator_core.sv */
// Three-phase sample generator: a phase accumulator drives six cosine
// channels (voltages and lagged currents, A/B/C) and neutral sums. Takes one
// request per clock; a result passes through the table-address register, the
// lookup/multiply register and the output register, and the whole pipeline
// stalls only while a finished result waits to be taken.
// Requests with sample_tick low are absorbed and give no result.
// Depends on tpsg_pkg, tpsg_if and tpsg_chan.
module three_phase_sample_generator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpsg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpsg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tpsg_req_if.sink                          req_i,
  tpsg_res_if.source                        res_o
);

  logic [tpsg_pkg::PHASE_W-1:0]  phase_step_q;
  logic [tpsg_pkg::LAG_W-1:0]    cur_lag_q;
  logic [tpsg_pkg::AMP_BITS-1:0] amp_q [6];

  logic [tpsg_pkg::PHASE_W-1:0]  phase_acc_q, phase_acc_d;
  logic [tpsg_pkg::IDX_W-1:0]    count_q, count_d;

  logic                                en;
  logic                                take;
  logic [tpsg_pkg::PHASE_W-1:0]        lag_w;
  logic [tpsg_pkg::PHASE_W-1:0]        ph_v [3];
  logic [tpsg_pkg::PHASE_W-1:0]        ph_all [6];

  logic                                s1_valid_q;
  logic [tpsg_pkg::IDX_W-1:0]          s1_idx_q;
  logic [tpsg_pkg::COS_TABLE_BITS-1:0] s1_tbl_q [6];

  logic                                s2_valid_q;
  logic [tpsg_pkg::IDX_W-1:0]          s2_idx_q;
  tpsg_pkg::chan_res_t                 ch_res [6];
  logic signed [tpsg_pkg::SAMPLE_W-1:0] val_d [6];

  logic                                 res_valid_q;
  logic [tpsg_pkg::IDX_W-1:0]           res_idx_q;
  logic signed [tpsg_pkg::SAMPLE_W-1:0] res_val_q [6];
  logic signed [tpsg_pkg::NEUTRAL_W-1:0] volt_n_q, cur_n_q;

  assign en          = !res_valid_q || res_o.ready;
  assign req_i.ready = en;
  assign take        = req_i.valid && en && req_i.sample_tick;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= tpsg_pkg::RST_PHASE_STEP;
      cur_lag_q    <= tpsg_pkg::RST_CUR_LAG;
      for (int i = 0; i < 3; i++) begin
        amp_q[i]     <= tpsg_pkg::RST_AMP_VOLT;
        amp_q[i + 3] <= tpsg_pkg::RST_AMP_CUR;
      end
    end else if (cfg_we_i) begin
      case (tpsg_pkg::cfg_idx_e'(cfg_idx_i))
        tpsg_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
        tpsg_pkg::CFG_CUR_LAG:    cur_lag_q    <= cfg_data_i[tpsg_pkg::LAG_W-1:0];
        tpsg_pkg::CFG_AMP_VOLT_A: amp_q[0] <= cfg_data_i[tpsg_pkg::AMP_BITS-1:0];
        tpsg_pkg::CFG_AMP_VOLT_B: amp_q[1] <= cfg_data_i[tpsg_pkg::AMP_BITS-1:0];
        tpsg_pkg::CFG_AMP_VOLT_C: amp_q[2] <= cfg_data_i[tpsg_pkg::AMP_BITS-1:0];
        tpsg_pkg::CFG_AMP_CUR_A:  amp_q[3] <= cfg_data_i[tpsg_pkg::AMP_BITS-1:0];
        tpsg_pkg::CFG_AMP_CUR_B:  amp_q[4] <= cfg_data_i[tpsg_pkg::AMP_BITS-1:0];
        tpsg_pkg::CFG_AMP_CUR_C:  amp_q[5] <= cfg_data_i[tpsg_pkg::AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // phase accumulator and sample counter
  always_comb begin
    if (count_q >= tpsg_pkg::LAST_INDEX) begin
      count_d     = '0;
      phase_acc_d = '0;
    end else begin
      count_d     = count_q + 1'b1;
      phase_acc_d = phase_acc_q + phase_step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      count_q     <= '0;
    end else if (take) begin
      phase_acc_q <= phase_acc_d;
      count_q     <= count_d;
    end
  end

  always_comb begin
    lag_w   = {cur_lag_q, {(tpsg_pkg::PHASE_W - tpsg_pkg::LAG_W){1'b0}}};
    ph_v[0] = phase_acc_q;
    ph_v[1] = phase_acc_q - tpsg_pkg::THIRD_TURN;
    ph_v[2] = phase_acc_q + tpsg_pkg::THIRD_TURN;
    for (int i = 0; i < 3; i++) begin
      ph_all[i]     = ph_v[i];
      ph_all[i + 3] = ph_v[i] - lag_w;
    end
  end

  // stage 1: table addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= req_i.valid && req_i.sample_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_idx_q <= count_q;
      for (int i = 0; i < 6; i++) begin
        s1_tbl_q[i] <=
          ph_all[i][tpsg_pkg::PHASE_W-1 -: tpsg_pkg::COS_TABLE_BITS];
      end
    end
  end

  // stage 2: lookup and multiply per channel
  for (genvar g = 0; g < 6; g++) begin : g_chan
    tpsg_chan u_chan (
      .clk_i    (clk_i),
      .en_i     (en),
      .tbl_idx_i(s1_tbl_q[g]),
      .amp_i    (amp_q[g]),
      .res_o    (ch_res[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_idx_q <= s1_idx_q;
    end
  end

  // stage 3: sign, neutral sums, result register
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      val_d[i] = ch_res[i].neg ? -$signed({1'b0, ch_res[i].mag})
                               :  $signed({1'b0, ch_res[i].mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_idx_q <= s2_idx_q;
      for (int i = 0; i < 6; i++) begin
        res_val_q[i] <= val_d[i];
      end
      volt_n_q <= tpsg_pkg::NEUTRAL_W'(val_d[0]) + tpsg_pkg::NEUTRAL_W'(val_d[1])
                + tpsg_pkg::NEUTRAL_W'(val_d[2]);
      cur_n_q  <= tpsg_pkg::NEUTRAL_W'(val_d[3]) + tpsg_pkg::NEUTRAL_W'(val_d[4])
                + tpsg_pkg::NEUTRAL_W'(val_d[5]);
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.sample_index = res_idx_q;
  assign res_o.volt_a       = res_val_q[0];
  assign res_o.volt_b       = res_val_q[1];
  assign res_o.volt_c       = res_val_q[2];
  assign res_o.volt_neutral = volt_n_q;
  assign res_o.cur_a        = res_val_q[3];
  assign res_o.cur_b        = res_val_q[4];
  assign res_o.cur_c        = res_val_q[5];
  assign res_o.cur_neutral  = cur_n_q;

endmodule

/* rtl/tpsg_chk.sv */
// Port-level checks for the sample generator, bound to the top level.
// Depends on tpsg_pkg and three_phase_sample_generator_core.
module tpsg_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  res_valid_i,
  input logic                                  res_ready_i,
  input logic [tpsg_pkg::IDX_W-1:0]            sample_index_i,
  input logic signed [tpsg_pkg::SAMPLE_W-1:0]  volt_a_i,
  input logic signed [tpsg_pkg::SAMPLE_W-1:0]  volt_b_i,
  input logic signed [tpsg_pkg::SAMPLE_W-1:0]  volt_c_i,
  input logic signed [tpsg_pkg::NEUTRAL_W-1:0] volt_neutral_i,
  input logic signed [tpsg_pkg::SAMPLE_W-1:0]  cur_a_i,
  input logic signed [tpsg_pkg::SAMPLE_W-1:0]  cur_b_i,
  input logic signed [tpsg_pkg::SAMPLE_W-1:0]  cur_c_i,
  input logic signed [tpsg_pkg::NEUTRAL_W-1:0] cur_neutral_i
);

  logic                       have_prev_q;
  logic [tpsg_pkg::IDX_W-1:0] prev_idx_q;
  logic [tpsg_pkg::IDX_W-1:0] exp_idx;
  logic                       res_take;

  assign res_take = res_valid_i && res_ready_i;
  assign exp_idx  = (prev_idx_q >= tpsg_pkg::LAST_INDEX) ? '0 : prev_idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_idx_q  <= '0;
    end else if (res_take) begin
      have_prev_q <= 1'b1;
      prev_idx_q  <= sample_index_i;
    end
  end

  a_volt_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> volt_neutral_i == tpsg_pkg::NEUTRAL_W'(volt_a_i)
      + tpsg_pkg::NEUTRAL_W'(volt_b_i) + tpsg_pkg::NEUTRAL_W'(volt_c_i))
    else $error("voltage neutral is not the phase sum");

  a_cur_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> cur_neutral_i == tpsg_pkg::NEUTRAL_W'(cur_a_i)
      + tpsg_pkg::NEUTRAL_W'(cur_b_i) + tpsg_pkg::NEUTRAL_W'(cur_c_i))
    else $error("current neutral is not the phase sum");

  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_take && have_prev_q) |-> sample_index_i == exp_idx)
    else $error("sample index out of sequence");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i && $stable(sample_index_i)
      && $stable(volt_neutral_i) && $stable(cur_neutral_i))
    else $error("stalled result changed");

endmodule

bind three_phase_sample_generator_core tpsg_chk u_tpsg_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .sample_index_i(res_o.sample_index),
  .volt_a_i      (res_o.volt_a),
  .volt_b_i      (res_o.volt_b),
  .volt_c_i      (res_o.volt_c),
  .volt_neutral_i(res_o.volt_neutral),
  .cur_a_i       (res_o.cur_a),
  .cur_b_i       (res_o.cur_b),
  .cur_c_i       (res_o.cur_c),
  .cur_neutral_i (res_o.cur_neutral)
);

/* sim/three_phase_sample_generator_core_tb.sv */
// Testbench for three_phase_sample_generator_core: a directed table and random
// request phases, every result checked against an in-bench sample predictor or typed row values.
// Depends on tpsg_pkg, tpsg_if and the generator RTL.
`timescale 1ns / 100ps

module three_phase_sample_generator_core_tb;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RST_CYCLES     = 3;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_IDLE       = 16;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RAND_PHASES    = 8;
  localparam int unsigned PHASE_TICKS    = 145;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam longint      CYCLE_LIMIT    = 1000000;
  localparam int unsigned TBL_FULL       = 2 ** tpsg_pkg::COS_TABLE_BITS;

  typedef struct packed {
    logic [tpsg_pkg::IDX_W-1:0]            sample_index;
    logic signed [tpsg_pkg::SAMPLE_W-1:0]  volt_a;
    logic signed [tpsg_pkg::SAMPLE_W-1:0]  volt_b;
    logic signed [tpsg_pkg::SAMPLE_W-1:0]  volt_c;
    logic signed [tpsg_pkg::NEUTRAL_W-1:0] volt_neutral;
    logic signed [tpsg_pkg::SAMPLE_W-1:0]  cur_a;
    logic signed [tpsg_pkg::SAMPLE_W-1:0]  cur_b;
    logic signed [tpsg_pkg::SAMPLE_W-1:0]  cur_c;
    logic signed [tpsg_pkg::NEUTRAL_W-1:0] cur_neutral;
  } sample_set_t;

  typedef struct packed {
    logic                            is_cfg;
    tpsg_pkg::cfg_idx_e              idx;
    logic [tpsg_pkg::CFG_DATA_W-1:0] data;
    logic                            tick;
    logic                            typed_idx;
    logic [tpsg_pkg::IDX_W-1:0]      t_idx;
    logic                            typed_a;
    logic [tpsg_pkg::SAMPLE_W-1:0]   t_va;
    logic [tpsg_pkg::SAMPLE_W-1:0]   t_ca;
  } dir_row_t;

  localparam int unsigned N_DIR = 34;

  dir_row_t dir_rows [N_DIR] = '{
    // after reset: phase zero, no lag, reset amplitudes
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd0, 1'b1, 25'd1555635, 25'd14142},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd1, 1'b0, 25'd0, 25'd0},
    // zero amplitudes
    '{1'b1, tpsg_pkg::CFG_AMP_VOLT_A, 32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_VOLT_B, 32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_VOLT_C, 32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_CUR_A,  32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_CUR_B,  32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_CUR_C,  32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd2, 1'b1, 25'd0, 25'd0},
    // full scale, upper register bits set
    '{1'b1, tpsg_pkg::CFG_AMP_VOLT_A, 32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_VOLT_B, 32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_VOLT_C, 32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_CUR_A,  32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_CUR_B,  32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_AMP_CUR_C,  32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_CUR_LAG,    32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd3, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd4, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd5, 1'b0, 25'd0, 25'd0},
    // half-turn lag
    '{1'b1, tpsg_pkg::CFG_CUR_LAG,    32'h0000_8000, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd6, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd7, 1'b0, 25'd0, 25'd0},
    // frozen phase
    '{1'b1, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd8, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd9, 1'b0, 25'd0, 25'd0},
    // half-turn step, quarter-turn lag
    '{1'b1, tpsg_pkg::CFG_PHASE_STEP, 32'h8000_0000, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b1, tpsg_pkg::CFG_CUR_LAG,    32'h0000_4000, 1'b0, 1'b0, 12'd0, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd10, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd11, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd12, 1'b0, 25'd0, 25'd0},
    '{1'b0, tpsg_pkg::CFG_PHASE_STEP, 32'h0, 1'b1, 1'b1, 12'd13, 1'b0, 25'd0, 25'd0}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [tpsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [tpsg_pkg::CFG_DATA_W-1:0] cfg_data_i;

  tpsg_req_if req_if ();
  tpsg_res_if res_if ();

  three_phase_sample_generator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state and register copy
  logic [tpsg_pkg::PHASE_W-1:0]  phase_acc;
  logic [tpsg_pkg::IDX_W-1:0]    sample_cnt;
  logic [tpsg_pkg::PHASE_W-1:0]  step_reg;
  logic [tpsg_pkg::LAG_W-1:0]    lag_reg;
  logic [tpsg_pkg::AMP_BITS-1:0] amp_volt [3];
  logic [tpsg_pkg::AMP_BITS-1:0] amp_cur [3];
  longint                        quarter_cos [tpsg_pkg::COS_QUARTER + 1];

  sample_set_t expected_samples [$];
  int unsigned mismatch_cnt;
  longint      cycle_cnt;
  logic        idle_on;
  int unsigned hold_cycles;

  function automatic longint series_cos(int unsigned m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    int unsigned n;
    x    = (64'(m) * tpsg_pkg::TWO_PI_Q30) >> tpsg_pkg::COS_TABLE_BITS;
    x2   = (x * x) >> tpsg_pkg::COS_FRAC;
    term = 64'd1 << tpsg_pkg::COS_FRAC;
    acc  = longint'(term);
    for (n = 1; n <= 8; n++) begin
      term = ((term * x2) >> tpsg_pkg::COS_FRAC) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << tpsg_pkg::COS_FRAC)) begin
      acc = longint'(1) << tpsg_pkg::COS_FRAC;
    end
    return acc;
  endfunction

  function automatic longint table_cos(logic [tpsg_pkg::COS_TABLE_BITS-1:0] k);
    int unsigned j;
    j = k;
    if (j > TBL_FULL / 2) begin
      j = TBL_FULL - j;
    end
    if (j > TBL_FULL / 4) begin
      return -quarter_cos[TBL_FULL / 2 - j];
    end
    return quarter_cos[j];
  endfunction

  function automatic longint channel_value(logic [tpsg_pkg::AMP_BITS-1:0] amp,
                                           logic [tpsg_pkg::PHASE_W-1:0] ph);
    longint      c;
    logic [63:0] mag;
    c   = table_cos(ph[tpsg_pkg::PHASE_W-1 -: tpsg_pkg::COS_TABLE_BITS]);
    mag = (64'(amp) * 64'(c < 0 ? -c : c)) >> tpsg_pkg::COS_FRAC;
    return c < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic sample_set_t next_sample_set();
    sample_set_t                  s;
    logic [tpsg_pkg::PHASE_W-1:0] ph [3];
    logic [tpsg_pkg::PHASE_W-1:0] lag;
    longint                       v [3];
    longint                       c [3];
    lag   = tpsg_pkg::PHASE_W'(lag_reg) << 16;
    ph[0] = phase_acc;
    ph[1] = phase_acc - tpsg_pkg::THIRD_TURN;
    ph[2] = phase_acc + tpsg_pkg::THIRD_TURN;
    for (int i = 0; i < 3; i++) begin
      v[i] = channel_value(amp_volt[i], ph[i]);
      c[i] = channel_value(amp_cur[i], ph[i] - lag);
    end
    s.sample_index = sample_cnt;
    s.volt_a       = tpsg_pkg::SAMPLE_W'(v[0]);
    s.volt_b       = tpsg_pkg::SAMPLE_W'(v[1]);
    s.volt_c       = tpsg_pkg::SAMPLE_W'(v[2]);
    s.volt_neutral = tpsg_pkg::NEUTRAL_W'(v[0] + v[1] + v[2]);
    s.cur_a        = tpsg_pkg::SAMPLE_W'(c[0]);
    s.cur_b        = tpsg_pkg::SAMPLE_W'(c[1]);
    s.cur_c        = tpsg_pkg::SAMPLE_W'(c[2]);
    s.cur_neutral  = tpsg_pkg::NEUTRAL_W'(c[0] + c[1] + c[2]);
    if (int'(sample_cnt) + 1 >= int'(tpsg_pkg::SAMPLES_PER_WRAP)) begin
      sample_cnt = '0;
      phase_acc  = '0;
    end else begin
      sample_cnt = sample_cnt + 1'b1;
      phase_acc  = phase_acc + step_reg;
    end
    return s;
  endfunction

  task automatic write_reg(input tpsg_pkg::cfg_idx_e idx,
                           input logic [tpsg_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tpsg_pkg::CFG_PHASE_STEP: step_reg = data;
      tpsg_pkg::CFG_CUR_LAG:    lag_reg = data[tpsg_pkg::LAG_W-1:0];
      tpsg_pkg::CFG_AMP_VOLT_A: amp_volt[0] = data[tpsg_pkg::AMP_BITS-1:0];
      tpsg_pkg::CFG_AMP_VOLT_B: amp_volt[1] = data[tpsg_pkg::AMP_BITS-1:0];
      tpsg_pkg::CFG_AMP_VOLT_C: amp_volt[2] = data[tpsg_pkg::AMP_BITS-1:0];
      tpsg_pkg::CFG_AMP_CUR_A:  amp_cur[0] = data[tpsg_pkg::AMP_BITS-1:0];
      tpsg_pkg::CFG_AMP_CUR_B:  amp_cur[1] = data[tpsg_pkg::AMP_BITS-1:0];
      tpsg_pkg::CFG_AMP_CUR_C:  amp_cur[2] = data[tpsg_pkg::AMP_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_req(input logic tick, input int unsigned gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.sample_tick <= tick;
    do @(posedge clk_i); while (!req_if.ready);
    if (tick) begin
      expected_samples.push_back(next_sample_set());
    end
  endtask

  // tick-0 requests leave nothing to wait on, so pad by at least the pipeline depth
  task automatic drain_pipe();
    req_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_random_settings();
    tpsg_pkg::cfg_idx_e              r;
    logic [tpsg_pkg::CFG_DATA_W-1:0] val;
    r = r.first();
    do begin
      case ($urandom_range(0, 3))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      write_reg(r, val);
      r = r.next();
    end while (r != r.first());
  endtask

  task automatic check_sample();
    sample_set_t got;
    sample_set_t exp;
    got = '{res_if.sample_index, res_if.volt_a, res_if.volt_b, res_if.volt_c,
            res_if.volt_neutral, res_if.cur_a, res_if.cur_b, res_if.cur_c,
            res_if.cur_neutral};
    if (expected_samples.size() == 0) begin
      if (mismatch_cnt < MAX_REPORTS) begin
        $display("unexpected sample set, index %0d", got.sample_index);
      end
      mismatch_cnt++;
      return;
    end
    exp = expected_samples.pop_front();
    if (got.sample_index !== exp.sample_index || got.volt_a !== exp.volt_a ||
        got.volt_b !== exp.volt_b || got.volt_c !== exp.volt_c ||
        got.volt_neutral !== exp.volt_neutral || got.cur_a !== exp.cur_a ||
        got.cur_b !== exp.cur_b || got.cur_c !== exp.cur_c ||
        got.cur_neutral !== exp.cur_neutral) begin
      if (mismatch_cnt < MAX_REPORTS) begin
        $display("sample mismatch exp idx %0d v %0d %0d %0d n %0d i %0d %0d %0d n %0d",
                 exp.sample_index, exp.volt_a, exp.volt_b, exp.volt_c, exp.volt_neutral,
                 exp.cur_a, exp.cur_b, exp.cur_c, exp.cur_neutral);
        $display("                got idx %0d v %0d %0d %0d n %0d i %0d %0d %0d n %0d",
                 got.sample_index, got.volt_a, got.volt_b, got.volt_c, got.volt_neutral,
                 got.cur_a, got.cur_b, got.cur_c, got.cur_neutral);
      end
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned wait_cycles;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      wait_cycles = (idle_on ? $urandom_range(0, MAX_IDLE) : 0) + hold_cycles;
      hold_cycles = 0;
      if (wait_cycles > 0) begin
        res_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      check_sample();
    end
  end

  initial begin : stimulus
    int unsigned ticks;
    int unsigned gap;
    logic        tick;
    cycle_cnt          = 0;
    mismatch_cnt       = 0;
    hold_cycles        = 0;
    idle_on            = 1'b1;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= tpsg_pkg::CFG_PHASE_STEP;
    cfg_data_i         <= '0;
    req_if.valid       <= 1'b0;
    req_if.sample_tick <= 1'b0;
    for (int m = 0; m <= tpsg_pkg::COS_QUARTER; m++) begin
      quarter_cos[m] = series_cos(m);
    end
    phase_acc  = '0;
    sample_cnt = '0;
    step_reg   = tpsg_pkg::RST_PHASE_STEP;
    lag_reg    = tpsg_pkg::RST_CUR_LAG;
    for (int i = 0; i < 3; i++) begin
      amp_volt[i] = tpsg_pkg::RST_AMP_VOLT;
      amp_cur[i]  = tpsg_pkg::RST_AMP_CUR;
    end
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        drain_pipe();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_req(dir_rows[r].tick, $urandom_range(0, MAX_IDLE));
        if (dir_rows[r].tick && dir_rows[r].typed_idx) begin
          expected_samples[expected_samples.size() - 1].sample_index = dir_rows[r].t_idx;
        end
        if (dir_rows[r].tick && dir_rows[r].typed_a) begin
          expected_samples[expected_samples.size() - 1].volt_a = dir_rows[r].t_va;
          expected_samples[expected_samples.size() - 1].cur_a  = dir_rows[r].t_ca;
        end
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_pipe();
      program_random_settings();
      idle_on = (p % 3 != 1);
      if (p == PRESSURE_PHASE) begin
        hold_cycles = HOLD_CYCLES;
      end
      ticks = 0;
      while (ticks < PHASE_TICKS) begin
        tick = ($urandom_range(0, 9) != 0);
        gap  = (idle_on && p != PRESSURE_PHASE) ? $urandom_range(0, MAX_IDLE) : 0;
        send_req(tick, gap);
        if (tick) begin
          ticks++;
        end
      end
    end

    idle_on = 1'b1;
    drain_pipe();
    if (mismatch_cnt == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tpsg_pkg.sv
rtl/tpsg_if.sv
rtl/tpsg_chan.sv
rtl/three_phase_sample_generator_core.sv
rtl/tpsg_chk.sv
sim/three_phase_sample_generator_core_tb.sv
